@@ rtl/vmp_pkg.sv @@
// Shared types and constants for the model-view / projection vertex transform.
package vmp_pkg;

   localparam int ELEM_WIDTH        = 32;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int COORD_WIDTH_DEF   = 32;
   localparam int NUM_ROWS          = 4;
   localparam int NUM_COLS          = 4;
   localparam int COL_BITS          = 2;
   localparam int INDEX_WIDTH       = 4;

   localparam logic KIND_LOAD       = 1'b0;
   localparam logic KIND_VERTEX     = 1'b1;
   localparam logic SEL_MODELVIEW   = 1'b0;
   localparam logic SEL_PROJECTION  = 1'b1;

   localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(NUM_COLS - 1);

   typedef logic [COL_BITS-1:0] col_type;

   // Per-cycle control broadcast from a phase sequencer to its cells
   typedef struct packed {
      logic    en;
      logic    issue;
      col_type col;
      logic    acc_valid;
      logic    acc_first;
   } cell_ctl_type;

   // Element write into one cell's matrix row
   typedef struct packed {
      logic                  we;
      col_type               col;
      logic [ELEM_WIDTH-1:0] value;
   } cell_load_type;

   // Element write into one phase's matrix
   typedef struct packed {
      logic                  we;
      col_type               row;
      col_type               col;
      logic [ELEM_WIDTH-1:0] value;
   } elem_load_type;

   typedef struct packed {
      logic work;
      logic res_valid;
   } phase_status_type;

endpackage

@@ rtl/vertex_modelview_projection.sv @@
// Top level of the model-view then projection 4x4 vertex transform.
//
// Usage: one input stream (req_) carries two kinds of transaction, told apart by
// req_tuser[0]. A load writes one element of the model-view or projection matrix
// (req_tuser[1] selects) at position row*4+column and produces no result. A vertex
// transaction carries x, y, z, w in signed fixed point and produces one result on
// the rsp_ stream: the four clip coordinates, with rsp_tuser[0] set if any product
// or sum was clamped on the way.
// Pacing: each phase's row of multiply-accumulate cells spends four column steps on
// one matrix-vector product and can take a new vertex while issuing the last column,
// unless stalled by a full result register; the model-view phase works on one vertex
// while the projection phase finishes the previous one.
// A load is accepted only when no vertex is in flight in either phase (a result
// waiting on rsp_ does not hold it back); the element is registered into the matrix.
// Reset clears both matrices to zero and drops all transactions in flight.
// When the receiver stalls, the result holds on rsp_ and the phases keep working
// until their result registers are full, then freeze in place.
module vertex_modelview_projection #(
   parameter int FRAC_BITS   = vmp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF,
   localparam int REQ_BITS   = vmp_pkg::INDEX_WIDTH + vmp_pkg::ELEM_WIDTH
                               + vmp_pkg::NUM_COLS * COORD_WIDTH,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = vmp_pkg::NUM_ROWS * COORD_WIDTH,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // element_index, element_value, vertex_x, vertex_y, vertex_z, vertex_w, zero fill
   input  logic [REQ_W-1:0] req_tdata,
   // kind, matrix_select
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // clip_x, clip_y, clip_z, clip_w, zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   // saturated
   output logic [0:0]       rsp_tuser
);
   import vmp_pkg::*;

   localparam int VALUE_LSB  = INDEX_WIDTH;
   localparam int VERTEX_LSB = INDEX_WIDTH + ELEM_WIDTH;

   logic                   kind;
   logic                   matrix_select;
   logic                   load_ready;
   logic                   load_accept;
   logic [COORD_WIDTH-1:0] vertex [NUM_COLS];
   logic [COORD_WIDTH-1:0] mid    [NUM_ROWS];
   logic [COORD_WIDTH-1:0] clip   [NUM_ROWS];
   logic                   mid_sat;
   logic                   clip_sat;
   logic                   a_in_valid, a_in_ready;
   logic                   mid_valid, b_in_ready;
   elem_load_type          ld_mv, ld_pr;
   phase_status_type       st_mv, st_pr;

   assign kind          = req_tuser[0];
   assign matrix_select = req_tuser[1];

   for (genvar c = 0; c < NUM_COLS; c++) begin : g_unpack
      assign vertex[c] = req_tdata[VERTEX_LSB + c*COORD_WIDTH +: COORD_WIDTH];
   end

   // Hold loads back while any vertex still reads the matrices
   assign load_ready  = !st_mv.work && !st_mv.res_valid && !st_pr.work;
   assign req_tready  = (kind == KIND_VERTEX) ? a_in_ready : load_ready;
   assign a_in_valid  = req_tvalid && (kind == KIND_VERTEX);
   assign load_accept = req_tvalid && load_ready && (kind == KIND_LOAD);

   assign ld_mv.we    = load_accept && (matrix_select == SEL_MODELVIEW);
   assign ld_mv.row   = req_tdata[INDEX_WIDTH-1:COL_BITS];
   assign ld_mv.col   = req_tdata[COL_BITS-1:0];
   assign ld_mv.value = req_tdata[VALUE_LSB +: ELEM_WIDTH];

   assign ld_pr.we    = load_accept && (matrix_select == SEL_PROJECTION);
   assign ld_pr.row   = ld_mv.row;
   assign ld_pr.col   = ld_mv.col;
   assign ld_pr.value = ld_mv.value;

   // Model-view phase: eye position from the input vertex
   vmp_phase #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_modelview (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_in_valid),
      .in_ready  (a_in_ready),
      .in_vec    (vertex),
      .in_sat    (1'b0),
      .ld        (ld_mv),
      .out_valid (mid_valid),
      .out_ready (b_in_ready),
      .out_vec   (mid),
      .out_sat   (mid_sat),
      .status    (st_mv)
   );

   // Projection phase: clip position; its result register drives the rsp_ stream
   vmp_phase #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_projection (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (b_in_ready),
      .in_vec    (mid),
      .in_sat    (mid_sat),
      .ld        (ld_pr),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_vec   (clip),
      .out_sat   (clip_sat),
      .status    (st_pr)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         rsp_tdata[r*COORD_WIDTH +: COORD_WIDTH] = clip[r];
      end
   end

   assign rsp_tuser[0] = clip_sat;

endmodule

@@ rtl/vmp_cell.sv @@
// One row cell: holds a matrix row, multiplies, rounds and accumulates one column a cycle while enabled.
module vmp_cell #(
   parameter int FRAC_BITS   = vmp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vmp_pkg::cell_ctl_type    ctl,
   input  vmp_pkg::cell_load_type   ld,
   input  logic [COORD_WIDTH-1:0]   coord,
   input  logic                     sat_chain_i,
   output logic [COORD_WIDTH-1:0]   sum_next_o,
   output logic                     sat_chain_o
);
   import vmp_pkg::*;

   localparam int PW = ELEM_WIDTH + COORD_WIDTH;
   localparam int QW = PW - FRAC_BITS;
   localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic [COORD_WIDTH-1:0] SUM_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SUM_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [ELEM_WIDTH-1:0]         elem_ff [NUM_COLS];
   logic [PW-1:0]                 prod_ff;
   logic [COORD_WIDTH-1:0]        rnd_ff,  rnd_in;
   logic                          rnd_sat_ff, rnd_sat_in;
   logic [COORD_WIDTH-1:0]        acc_ff;
   logic                          acc_sat_ff;

   logic signed [ELEM_WIDTH-1:0]  elem_s;
   logic signed [COORD_WIDTH-1:0] coord_s;
   logic signed [PW-1:0]          prod_in;
   logic [PW-1:0]                 biased;
   logic [QW-1:0]                 quot;
   logic [QW-COORD_WIDTH:0]       quot_top;
   logic [COORD_WIDTH-1:0]        base;
   logic [COORD_WIDTH:0]          sum_wide;
   logic                          add_sat;
   logic                          sat_next;

   // Matrix row; reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            elem_ff[c] <= '0;
         end
      end else if (ld.we) begin
         elem_ff[ld.col] <= ld.value;
      end
   end

   assign elem_s  = $signed(elem_ff[ctl.col]);
   assign coord_s = $signed(coord);
   assign prod_in = elem_s * coord_s;

   // Round to nearest, ties away from zero: bias negatives one less, then shift
   assign biased   = prod_ff + HALF - {{(PW-1){1'b0}}, prod_ff[PW-1]};
   assign quot     = biased[PW-1:FRAC_BITS];
   assign quot_top = quot[QW-1:COORD_WIDTH-1];

   always_comb begin
      if ((&quot_top) || !(|quot_top)) begin
         rnd_in     = quot[COORD_WIDTH-1:0];
         rnd_sat_in = 1'b0;
      end else begin
         rnd_in     = quot[QW-1] ? SUM_MIN : SUM_MAX;
         rnd_sat_in = 1'b1;
      end
   end

   // Saturating accumulate
   assign base     = ctl.acc_first ? '0 : acc_ff;
   assign sum_wide = {base[COORD_WIDTH-1], base} + {rnd_ff[COORD_WIDTH-1], rnd_ff};
   assign add_sat  = sum_wide[COORD_WIDTH] ^ sum_wide[COORD_WIDTH-1];

   always_comb begin
      if (add_sat) begin
         sum_next_o = sum_wide[COORD_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_next_o = sum_wide[COORD_WIDTH-1:0];
      end
   end

   assign sat_next    = rnd_sat_ff | add_sat | (!ctl.acc_first & acc_sat_ff);
   assign sat_chain_o = sat_chain_i | sat_next;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (ctl.issue) begin
            prod_ff <= PW'(prod_in);
         end
         rnd_ff     <= rnd_in;
         rnd_sat_ff <= rnd_sat_in;
         if (ctl.acc_valid) begin
            acc_ff     <= sum_next_o;
            acc_sat_ff <= sat_next;
         end
      end
   end

endmodule

@@ rtl/vmp_phase.sv @@
// One matrix-vector phase: column sequencer, row of four cells and result register.
module vmp_phase #(
   parameter int FRAC_BITS   = vmp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [COORD_WIDTH-1:0]    in_vec [vmp_pkg::NUM_ROWS],
   input  logic                      in_sat,
   input  vmp_pkg::elem_load_type    ld,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [COORD_WIDTH-1:0]    out_vec [vmp_pkg::NUM_ROWS],
   output logic                      out_sat,
   output vmp_pkg::phase_status_type status
);
   import vmp_pkg::*;

   logic [COORD_WIDTH-1:0] vec_ff [NUM_COLS];
   logic                   vec_sat_ff;
   logic                   busy_ff;
   col_type                col_ff;
   logic                   mul_valid_ff, mul_first_ff, mul_last_ff, mul_insat_ff;
   logic                   rnd_valid_ff, rnd_first_ff, rnd_last_ff, rnd_insat_ff;
   logic [COORD_WIDTH-1:0] res_ff [NUM_ROWS];
   logic                   res_sat_ff;
   logic                   res_valid_ff;

   logic                   en;
   logic                   accept;
   logic                   issue;
   logic                   finish;
   cell_ctl_type           ctl;
   logic [COORD_WIDTH-1:0] sum_next [NUM_ROWS];
   logic                   sat_chain [NUM_ROWS+1];

   // Freeze the row while a finished result cannot be stored
   assign en       = !(rnd_valid_ff && rnd_last_ff && res_valid_ff && !out_ready);
   assign in_ready = !busy_ff || (en && col_ff == LAST_COL);
   assign accept   = in_valid && in_ready;
   assign issue    = busy_ff && en;
   assign finish   = en && rnd_valid_ff && rnd_last_ff;

   assign ctl.en        = en;
   assign ctl.issue     = issue;
   assign ctl.col       = col_ff;
   assign ctl.acc_valid = rnd_valid_ff;
   assign ctl.acc_first = rnd_first_ff;

   assign sat_chain[0] = 1'b0;

   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      cell_load_type cell_ld;

      assign cell_ld.we    = ld.we && (ld.row == COL_BITS'(r));
      assign cell_ld.col   = ld.col;
      assign cell_ld.value = ld.value;

      vmp_cell #(
         .FRAC_BITS   (FRAC_BITS),
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .ld          (cell_ld),
         .coord       (vec_ff[col_ff]),
         .sat_chain_i (sat_chain[r]),
         .sum_next_o  (sum_next[r]),
         .sat_chain_o (sat_chain[r+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         col_ff       <= '0;
         mul_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            col_ff  <= '0;
         end else if (issue) begin
            col_ff <= col_ff + 1'b1;
            if (col_ff == LAST_COL) begin
               busy_ff <= 1'b0;
            end
         end
         if (en) begin
            mul_valid_ff <= issue;
            rnd_valid_ff <= mul_valid_ff;
         end
         if (finish) begin
            res_valid_ff <= 1'b1;
         end else if (out_ready) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            vec_ff[c] <= in_vec[c];
         end
         vec_sat_ff <= in_sat;
      end
      if (en) begin
         mul_first_ff <= (col_ff == '0);
         mul_last_ff  <= (col_ff == LAST_COL);
         mul_insat_ff <= vec_sat_ff;
         rnd_first_ff <= mul_first_ff;
         rnd_last_ff  <= mul_last_ff;
         rnd_insat_ff <= mul_insat_ff;
      end
      if (finish) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            res_ff[r] <= sum_next[r];
         end
         res_sat_ff <= sat_chain[NUM_ROWS] | rnd_insat_ff;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_vec   = res_ff;
   assign out_sat   = res_sat_ff;

   assign status.work      = busy_ff | mul_valid_ff | rnd_valid_ff;
   assign status.res_valid = res_valid_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!res_valid_ff || out_ready))
      else $error("phase result overwritten before it was taken");

   a_last_flows: assert property (@(posedge clock) disable iff (reset)
      (en && mul_valid_ff && mul_last_ff) |=> (rnd_valid_ff && rnd_last_ff))
      else $error("last column lost between multiply and round stages");

   a_accept_at_end: assert property (@(posedge clock) disable iff (reset)
      (accept && busy_ff) |-> (issue && col_ff == LAST_COL))
      else $error("new vector taken before the last column was issued");

   a_first_issue: assert property (@(posedge clock) disable iff (reset)
      (accept && !busy_ff) |=> (col_ff == '0 && busy_ff))
      else $error("sequencer did not start at column zero");
`endif

endmodule
